// ===== src/i2cm_pkg.sv =====
package i2cm_pkg;

  // Sequencer phases of one bus transaction.
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START1 = 4'd1,
    PH_CTRL_W = 4'd2,
    PH_ADDR_H = 4'd3,
    PH_ADDR_L = 4'd4,
    PH_DATA   = 4'd5,
    PH_START2 = 4'd6,
    PH_CTRL_R = 4'd7,
    PH_READ   = 4'd8,
    PH_STOP   = 4'd9
  } phase_e;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  localparam int unsigned DevAddrW   = 7;
  localparam int unsigned InDataW    = 40;
  localparam int unsigned OutDataW   = 16;
  localparam logic [DevAddrW-1:0] DevAddrReset = 7'd80;

  // Sub-step codes within a bit slot group.
  localparam logic [1:0] SubFirst  = 2'd0;
  localparam logic [1:0] SubSecond = 2'd1;
  localparam logic [1:0] SubThird  = 2'd2;

  // Number of data bits in a byte; the acknowledge slot follows them.
  localparam logic [3:0] BitsPerByte = 4'd8;

  // One input request after unpacking.
  typedef struct packed {
    op_e         opcode;
    logic [15:0] mem_address;
    logic [7:0]  write_data;
    logic [7:0]  byte_count;
    logic        sda_in;
  } req_t;

  // One result request.
  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       ack_ok;
  } res_t;

endpackage

// ===== src/i2cm_seq.sv =====
module i2cm_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [i2cm_pkg::DevAddrW-1:0]    cfg_wdata_i,
  input  logic                             step_i,
  input  i2cm_pkg::req_t                   req_i,
  output i2cm_pkg::res_t                   res_o
);
  import i2cm_pkg::*;

  logic [DevAddrW-1:0] dev_addr_q;
  phase_e              phase_q, phase_d;
  logic [3:0]          bit_q, bit_d;
  logic [1:0]          sub_q, sub_d;
  logic [7:0]          shift_q, shift_d;
  logic [15:0]         target_q, target_d;
  logic [7:0]          remaining_q, remaining_d;
  logic                is_read_q, is_read_d;
  logic                ack_q, ack_d;
  logic                scl_q, scl_d;
  logic                sda_q, sda_d;
  logic                sda_line;
  logic                release_after;
  logic                rvalid;
  logic                rlast;
  logic                do_enter;
  phase_e              enter_ph;

  // Byte to be shifted out on entry to a phase.
  function automatic logic [7:0] load_shift(phase_e ph, logic [DevAddrW-1:0] dev,
                                            logic [15:0] addr, logic [7:0] rem);
    logic [7:0] val;
    case (ph)
      PH_CTRL_W: val = {dev, 1'b0};
      PH_ADDR_H: val = addr[15:8];
      PH_ADDR_L: val = addr[7:0];
      PH_DATA:   val = rem;
      PH_CTRL_R: val = {dev, 1'b1};
      default:   val = 8'h00;
    endcase
    return val;
  endfunction

  // Device address register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DevAddrReset;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  // One slot of the bus sequence per accepted tick; a command sets up a transaction while idle.
  always_comb begin
    phase_d       = phase_q;
    bit_d         = bit_q;
    sub_d         = sub_q;
    shift_d       = shift_q;
    target_d      = target_q;
    remaining_d   = remaining_q;
    is_read_d     = is_read_q;
    ack_d         = ack_q;
    scl_d         = scl_q;
    sda_line      = sda_q;
    release_after = 1'b0;
    rvalid        = 1'b0;
    rlast         = 1'b0;
    do_enter      = 1'b0;
    enter_ph      = PH_IDLE;

    if (step_i) begin
      case (req_i.opcode)
        OP_WRITE, OP_READ: begin
          if (phase_q == PH_IDLE) begin
            target_d    = req_i.mem_address;
            is_read_d   = (req_i.opcode == OP_READ);
            remaining_d = (req_i.opcode == OP_READ) ? req_i.byte_count : req_i.write_data;
            do_enter    = 1'b1;
            enter_ph    = PH_START1;
          end
        end
        OP_TICK: begin
          case (phase_q)
            PH_IDLE: ;
            PH_START1, PH_START2: begin
              if (sub_q == SubFirst) begin
                sda_line = 1'b1;
                scl_d    = 1'b1;
                sub_d    = SubSecond;
              end else if (sub_q == SubSecond) begin
                sda_line = 1'b0;
                sub_d    = SubThird;
              end else begin
                scl_d    = 1'b0;
                do_enter = 1'b1;
                enter_ph = (phase_q == PH_START1) ? PH_CTRL_W : PH_CTRL_R;
              end
            end
            PH_STOP: begin
              if (sub_q == SubFirst) begin
                sda_line = 1'b0;
                scl_d    = 1'b0;
                sub_d    = SubSecond;
              end else if (sub_q == SubSecond) begin
                scl_d = 1'b1;
                sub_d = SubThird;
              end else begin
                sda_line = 1'b1;
                do_enter = 1'b1;
                enter_ph = PH_IDLE;
              end
            end
            PH_READ: begin
              if (bit_q < BitsPerByte) begin
                if (sub_q == SubFirst) begin
                  sda_line = 1'b1;
                  scl_d    = 1'b1;
                  shift_d  = {shift_q[6:0], req_i.sda_in};
                  sub_d    = SubSecond;
                end else begin
                  scl_d = 1'b0;
                  sub_d = SubFirst;
                  bit_d = 4'(bit_q + 4'd1);
                end
              end else if (sub_q == SubFirst) begin
                // NACK on the final byte, ACK otherwise.
                sda_line = (remaining_q == 8'd1);
                sub_d    = SubSecond;
              end else if (sub_q == SubSecond) begin
                scl_d = 1'b1;
                sub_d = SubThird;
              end else begin
                scl_d         = 1'b0;
                rvalid        = 1'b1;
                rlast         = (remaining_q == 8'd1);
                remaining_d   = 8'(remaining_q - 8'd1);
                release_after = 1'b1;
                do_enter      = 1'b1;
                enter_ph      = (remaining_q == 8'd1) ? PH_STOP : PH_READ;
              end
            end
            PH_CTRL_W, PH_ADDR_H, PH_ADDR_L, PH_DATA, PH_CTRL_R: begin
              if (bit_q < BitsPerByte) begin
                if (sub_q == SubFirst) begin
                  sda_line = shift_q[7];
                  sub_d    = SubSecond;
                end else if (sub_q == SubSecond) begin
                  scl_d = 1'b1;
                  sub_d = SubThird;
                end else begin
                  scl_d   = 1'b0;
                  shift_d = {shift_q[6:0], 1'b0};
                  sub_d   = SubFirst;
                  bit_d   = 4'(bit_q + 4'd1);
                end
              end else if (sub_q == SubFirst) begin
                sda_line = 1'b1;
                sub_d    = SubSecond;
              end else if (sub_q == SubSecond) begin
                scl_d = 1'b1;
                ack_d = ~req_i.sda_in;
                sub_d = SubThird;
              end else begin
                scl_d    = 1'b0;
                do_enter = 1'b1;
                case (phase_q)
                  PH_CTRL_W: enter_ph = PH_ADDR_H;
                  PH_ADDR_H: enter_ph = PH_ADDR_L;
                  PH_ADDR_L: enter_ph = is_read_q ? PH_START2 : PH_DATA;
                  PH_CTRL_R: enter_ph = (remaining_q == 8'd0) ? PH_STOP : PH_READ;
                  default:   enter_ph = PH_STOP;
                endcase
              end
            end
            default: begin
              do_enter = 1'b1;
              enter_ph = PH_IDLE;
            end
          endcase
        end
        default: ;
      endcase
    end

    // Entering a phase restarts its bit and slot counters.
    if (do_enter) begin
      phase_d = enter_ph;
      bit_d   = 4'd0;
      sub_d   = SubFirst;
      shift_d = load_shift(enter_ph, dev_addr_q, target_d, remaining_d);
    end

    sda_d = release_after ? 1'b1 : sda_line;
  end

  // Result of this slot.
  always_comb begin
    res_o.scl_level   = scl_d;
    res_o.sda_release = sda_line;
    res_o.busy_res    = (phase_d != PH_IDLE);
    res_o.read_valid  = rvalid;
    res_o.read_data   = rvalid ? shift_q : 8'h00;
    res_o.read_last   = rlast;
    res_o.ack_ok      = ack_d;
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_q       <= 4'd0;
      sub_q       <= SubFirst;
      shift_q     <= 8'h00;
      target_q    <= 16'h0000;
      remaining_q <= 8'h00;
      is_read_q   <= 1'b0;
      ack_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
    end else begin
      phase_q     <= phase_d;
      bit_q       <= bit_d;
      sub_q       <= sub_d;
      shift_q     <= shift_d;
      target_q    <= target_d;
      remaining_q <= remaining_d;
      is_read_q   <= is_read_d;
      ack_q       <= ack_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
    end
  end

endmodule

// ===== src/i2cm_skid.sv =====
module i2cm_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  i2cm_pkg::res_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output i2cm_pkg::res_t out_data_o
);
  import i2cm_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_data_q, out_data_d;
  res_t skid_data_q, skid_data_d;

  assign in_ready_o  = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The output stage refills from the skid stage first, else from the input.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_valid_i;
        out_data_d  = in_data_i;
      end
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_d = 1'b1;
      skid_data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

endmodule

// ===== src/i2c_eeprom_master_core.sv =====
// I2C master for a serial EEPROM with a 16-bit memory address. A write or a
// read request (tuser) is taken only while idle and sets up the transaction;
// each following tick request stands for one slot of the bus sequence,
// and its result reports the SCL and SDA levels to drive during that slot
// together with busy, the last acknowledge seen and, on the slot that
// completes a received byte, the byte itself with tlast on the final one.
// One request is taken every clock cycle while input ready is high: the
// slot is decoded from the sequencer registers in a single pass and its
// result is registered in a two-entry output buffer, so input ready drops
// only when two results wait unread.
module i2c_eeprom_master_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration: seven-bit device address.
  input  logic                                cfg_we_i,
  input  logic [i2cm_pkg::DevAddrW-1:0]       cfg_wdata_i,
  // Input requests.
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // From bit 0: mem_address[15:0], write_data[7:0], byte_count[7:0], sda_in,
  // zero fill.
  input  logic [i2cm_pkg::InDataW-1:0]        s_axis_tdata_i,
  // opcode[1:0].
  input  logic [1:0]                          s_axis_tuser_i,
  // Results.
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // From bit 0: scl_level, sda_release, busy_res, read_valid, read_data[7:0],
  // ack_ok, zero fill.
  output logic [i2cm_pkg::OutDataW-1:0]       m_axis_tdata_o,
  // read_last.
  output logic                                m_axis_tlast_o
);
  import i2cm_pkg::*;

  req_t req;
  res_t step_res;
  res_t out_res;
  logic step;

  // Unpack the input request.
  always_comb begin
    req.opcode      = op_e'(s_axis_tuser_i);
    req.mem_address = s_axis_tdata_i[15:0];
    req.write_data  = s_axis_tdata_i[23:16];
    req.byte_count  = s_axis_tdata_i[31:24];
    req.sda_in      = s_axis_tdata_i[32];
  end

  assign step = s_axis_tvalid_i && s_axis_tready_o;

  i2cm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .req_i       (req),
    .res_o       (step_res)
  );

  i2cm_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (step_res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_res)
  );

  // Pack the result request.
  assign m_axis_tdata_o = {3'b000, out_res.ack_ok, out_res.read_data, out_res.read_valid,
                           out_res.busy_res, out_res.sda_release, out_res.scl_level};
  assign m_axis_tlast_o = out_res.read_last;

  // A last flag only ever comes with a received byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> m_axis_tdata_o[3])
    else $error("read_last without read_valid");

  // A received byte is always followed by at least the stop, so busy holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[3]) |-> m_axis_tdata_o[2])
    else $error("read byte reported while not busy");

  // Input back-pressure only follows a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> $past(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without output back-pressure");

endmodule

// ===== tb/i2c_slot_checker.sv =====
`timescale 1ns / 1ps

module i2c_slot_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [i2cm_pkg::DevAddrW-1:0] cfg_wdata_i,
  input  logic                          req_valid_i,
  input  logic                          req_ready_i,
  input  logic [i2cm_pkg::InDataW-1:0]  req_data_i,
  input  logic [1:0]                    req_user_i,
  input  logic                          res_valid_i,
  input  logic                          res_ready_i,
  input  logic [i2cm_pkg::OutDataW-1:0] res_data_i,
  input  logic                          res_last_i,
  output int                            mismatch_count_o,
  output int                            slots_pending_o,
  output logic                          bus_idle_o
);
  import i2cm_pkg::*;

  // Predicted sequencer state, with the device address it puts on the bus.
  phase_e              phase_q;
  logic [3:0]          bit_q;
  logic [1:0]          sub_q;
  logic [7:0]          shift_q;
  logic [15:0]         target_q;
  logic [7:0]          remain_q;
  logic                read_mode_q;
  logic                acked_q;
  logic                scl_q;
  logic                sda_q;
  logic [DevAddrW-1:0] dev_addr_q;

  // Slot results still owed by the block, oldest first.
  res_t slots_due[$];
  int   mismatches;
  int   pending;

  assign mismatch_count_o = mismatches;
  assign slots_pending_o  = pending;
  assign bus_idle_o       = (phase_q == PH_IDLE);

  // Moves to a new phase and loads the byte that it will shift out.
  task enter_phase(input phase_e nxt);
    phase_q = nxt;
    bit_q   = '0;
    sub_q   = SubFirst;
    case (nxt)
      PH_CTRL_W: shift_q = {dev_addr_q, 1'b0};
      PH_ADDR_H: shift_q = target_q[15:8];
      PH_ADDR_L: shift_q = target_q[7:0];
      PH_DATA:   shift_q = remain_q;
      PH_CTRL_R: shift_q = {dev_addr_q, 1'b1};
      default:   shift_q = '0;
    endcase
  endtask

  // Chooses what follows a byte that has been sent, acknowledged or not.
  task follow_sent_byte();
    case (phase_q)
      PH_CTRL_W: enter_phase(PH_ADDR_H);
      PH_ADDR_H: enter_phase(PH_ADDR_L);
      PH_ADDR_L: enter_phase(read_mode_q ? PH_START2 : PH_DATA);
      PH_CTRL_R: enter_phase(remain_q == 8'd0 ? PH_STOP : PH_READ);
      default:   enter_phase(PH_STOP);
    endcase
  endtask

  // Works out the line levels and status for one request and advances the state.
  task predict_slot(input req_t req, output res_t res);
    logic release_sda;
    res         = '0;
    release_sda = 1'b0;
    if (req.opcode == OP_WRITE || req.opcode == OP_READ) begin
      // A command only sets up a transfer, and only while the bus is free.
      if (phase_q == PH_IDLE) begin
        target_q    = req.mem_address;
        read_mode_q = (req.opcode == OP_READ);
        remain_q    = read_mode_q ? req.byte_count : req.write_data;
        enter_phase(PH_START1);
      end
    end else if (req.opcode == OP_TICK && phase_q != PH_IDLE) begin
      case (phase_q)
        PH_START1, PH_START2: begin
          if (sub_q == SubFirst) begin
            sda_q = 1'b1;
            scl_q = 1'b1;
            sub_q = SubSecond;
          end else if (sub_q == SubSecond) begin
            sda_q = 1'b0;
            sub_q = SubThird;
          end else begin
            scl_q = 1'b0;
            enter_phase(phase_q == PH_START1 ? PH_CTRL_W : PH_CTRL_R);
          end
        end
        PH_STOP: begin
          if (sub_q == SubFirst) begin
            sda_q = 1'b0;
            scl_q = 1'b0;
            sub_q = SubSecond;
          end else if (sub_q == SubSecond) begin
            scl_q = 1'b1;
            sub_q = SubThird;
          end else begin
            sda_q = 1'b1;
            enter_phase(PH_IDLE);
          end
        end
        PH_READ: begin
          if (bit_q < BitsPerByte) begin
            // Data bits are taken in while the clock is high.
            if (sub_q == SubFirst) begin
              sda_q   = 1'b1;
              scl_q   = 1'b1;
              shift_q = {shift_q[6:0], req.sda_in};
              sub_q   = SubSecond;
            end else begin
              scl_q = 1'b0;
              sub_q = SubFirst;
              bit_q = bit_q + 4'd1;
            end
          end else if (sub_q == SubFirst) begin
            // The final byte is refused, all others are acknowledged.
            sda_q = (remain_q == 8'd1);
            sub_q = SubSecond;
          end else if (sub_q == SubSecond) begin
            scl_q = 1'b1;
            sub_q = SubThird;
          end else begin
            scl_q          = 1'b0;
            res.read_valid = 1'b1;
            res.read_data  = shift_q;
            res.read_last  = (remain_q == 8'd1);
            remain_q       = remain_q - 8'd1;
            release_sda    = 1'b1;
            enter_phase(remain_q == 8'd0 ? PH_STOP : PH_READ);
          end
        end
        PH_CTRL_W, PH_ADDR_H, PH_ADDR_L, PH_DATA, PH_CTRL_R: begin
          if (bit_q < BitsPerByte) begin
            if (sub_q == SubFirst) begin
              sda_q = shift_q[7];
              sub_q = SubSecond;
            end else if (sub_q == SubSecond) begin
              scl_q = 1'b1;
              sub_q = SubThird;
            end else begin
              scl_q   = 1'b0;
              shift_q = {shift_q[6:0], 1'b0};
              sub_q   = SubFirst;
              bit_q   = bit_q + 4'd1;
            end
          end else if (sub_q == SubFirst) begin
            sda_q = 1'b1;
            sub_q = SubSecond;
          end else if (sub_q == SubSecond) begin
            // The acknowledge is only recorded; it never stops the transfer.
            scl_q   = 1'b1;
            acked_q = !req.sda_in;
            sub_q   = SubThird;
          end else begin
            scl_q = 1'b0;
            follow_sent_byte();
          end
        end
        default: enter_phase(PH_IDLE);
      endcase
    end
    res.scl_level   = scl_q;
    res.sda_release = sda_q;
    res.busy_res    = (phase_q != PH_IDLE);
    res.ack_ok      = acked_q;
    // After a received byte is reported the data line is let go again.
    if (release_sda) begin
      sda_q = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Results are compared before the request of the same edge is predicted,
  // since a result always belongs to an earlier request.
  always @(posedge clk_i or negedge rst_ni) begin
    req_t req;
    res_t want;
    if (!rst_ni) begin
      dev_addr_q  = DevAddrReset;
      phase_q     = PH_IDLE;
      bit_q       = '0;
      sub_q       = SubFirst;
      shift_q     = '0;
      target_q    = '0;
      remain_q    = '0;
      read_mode_q = 1'b0;
      acked_q     = 1'b0;
      scl_q       = 1'b1;
      sda_q       = 1'b1;
      slots_due.delete();
      mismatches  = 0;
      pending     = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (slots_due.size() == 0) begin
          mismatches++;
          $display("%0t ns: result expected none, got %h last %b", $time, res_data_i,
                   res_last_i);
        end else begin
          want = slots_due.pop_front();
          check_field("scl_level", 8'(want.scl_level), 8'(res_data_i[0]));
          check_field("sda_release", 8'(want.sda_release), 8'(res_data_i[1]));
          check_field("busy", 8'(want.busy_res), 8'(res_data_i[2]));
          check_field("read_valid", 8'(want.read_valid), 8'(res_data_i[3]));
          check_field("read_data", want.read_data, res_data_i[11:4]);
          check_field("ack_ok", 8'(want.ack_ok), 8'(res_data_i[12]));
          check_field("read_last", 8'(want.read_last), 8'(res_last_i));
        end
      end
      if (req_valid_i && req_ready_i) begin
        req.opcode      = op_e'(req_user_i);
        req.mem_address = req_data_i[15:0];
        req.write_data  = req_data_i[23:16];
        req.byte_count  = req_data_i[31:24];
        req.sda_in      = req_data_i[32];
        predict_slot(req, want);
        slots_due.push_back(want);
      end
      if (cfg_we_i) begin
        dev_addr_q = cfg_wdata_i;
      end
      pending = slots_due.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import i2cm_pkg::*;

  localparam int ItemTarget = 700;
  localparam int CycleLimit = 100_000;

  // Data line behaviour of the memory model during a transfer.
  localparam int SdaLow    = 0;
  localparam int SdaHigh   = 1;
  localparam int SdaRandom = 2;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [DevAddrW-1:0] cfg_wdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic [1:0]          s_tuser;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;

  int   mismatch_count;
  int   slots_pending;
  logic bus_idle;
  int   src_idle_pct = 26;
  int   snk_idle_pct = 84;
  int   sent_items = 0;
  int   cycles = 0;

  i2c_eeprom_master_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  i2c_slot_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .req_valid_i      (s_tvalid),
    .req_ready_i      (s_tready),
    .req_data_i       (s_tdata),
    .req_user_i       (s_tuser),
    .res_valid_i      (m_tvalid),
    .res_ready_i      (m_tready),
    .res_data_i       (m_tdata),
    .res_last_i       (m_tlast),
    .mismatch_count_o (mismatch_count),
    .slots_pending_o  (slots_pending),
    .bus_idle_o       (bus_idle)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // The result side stalls at random, changing only on the falling edge.
  always @(negedge clk) begin
    m_tready = ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offers one request after a random gap and returns on the falling edge
  // after it has been taken. The stall pattern follows the share of the run
  // already sent: receiver mostly stalled first, then the sender, then neither.
  task automatic drive_request(input op_e op, input logic [15:0] addr,
                               input logic [7:0] wdata, input logic [7:0] count,
                               input logic sda);
    if (sent_items < ItemTarget / 3) begin
      src_idle_pct = 26;
      snk_idle_pct = 84;
    end else if (sent_items < 2 * ItemTarget / 3) begin
      src_idle_pct = 84;
      snk_idle_pct = 26;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {7'd0, sda, count, wdata, addr};
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    sent_items++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  function automatic logic pick_sda(input int mode);
    if (mode == SdaLow) begin
      return 1'b0;
    end
    if (mode == SdaHigh) begin
      return 1'b1;
    end
    return 1'($urandom_range(0, 1));
  endfunction

  // A time slot, with random content in the fields it does not use.
  task automatic slot_tick(input int mode);
    drive_request(OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom), pick_sda(mode));
  endtask

  // Issues a command and clocks slots until the bus is free again, with
  // stray commands mixed in while it is busy.
  task automatic run_transfer(input op_e op, input logic [15:0] addr,
                              input logic [7:0] wdata, input logic [7:0] count,
                              input int mode, input int noise_pct);
    op_e stray;
    drive_request(op, addr, wdata, count, pick_sda(mode));
    while (!bus_idle) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 2))
          0:       stray = OP_WRITE;
          1:       stray = OP_READ;
          default: stray = OP_NOP;
        endcase
        drive_request(stray, 16'($urandom), 8'($urandom), 8'($urandom),
                      pick_sda(SdaRandom));
      end
      slot_tick(mode);
    end
  endtask

  // The address register is only changed once every slot has been reported.
  task automatic set_device_address(input logic [DevAddrW-1:0] value);
    while (slots_pending != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_TICK;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed transfers at the reset address: field extremes, a memory that
    // never acknowledges and a read of no bytes at all.
    run_transfer(OP_WRITE, 16'hFFFF, 8'hFF, 8'hFF, SdaHigh, 0);
    run_transfer(OP_READ, 16'h5A3C, 8'hFF, 8'd0, SdaLow, 0);

    // A slot and a no-op while the bus is free change nothing.
    slot_tick(SdaRandom);
    drive_request(OP_NOP, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);

    // Commands arriving in the middle of a read are ignored.
    run_transfer(OP_READ, 16'h1234, 8'h00, 8'd3, SdaRandom, 30);

    // Both ends of the device address, with a single-byte read.
    set_device_address(7'h00);
    run_transfer(OP_WRITE, 16'($urandom), 8'($urandom), 8'h00, SdaRandom, 0);
    set_device_address(7'h7F);
    run_transfer(OP_READ, 16'($urandom), 8'($urandom), 8'd1, SdaRandom, 0);

    // Short random transfers at a random device address fill up the run.
    set_device_address(7'($urandom));
    while (sent_items < ItemTarget) begin
      if ($urandom_range(0, 1) == 0) begin
        run_transfer(OP_WRITE, 16'($urandom), 8'($urandom), 8'($urandom), SdaRandom, 3);
      end else begin
        run_transfer(OP_READ, 16'($urandom), 8'($urandom), 8'($urandom_range(0, 2)),
                     SdaRandom, 3);
      end
    end

    // Drain the outstanding slots, then allow a little settling time.
    while (slots_pending != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/i2cm_pkg.sv
src/i2cm_seq.sv
src/i2cm_skid.sv
src/i2c_eeprom_master_core.sv
tb/i2c_slot_checker.sv
tb/testbench.sv
